// ===== hw/rtl/tsd_pkg.sv =====
package tsd_pkg;

  // packet geometry
  localparam int PACKET_BYTES_DEF = 188;
  localparam int TS_LIMIT         = 188;

  // configuration register reset values and indexes
  localparam logic [7:0] VIDEO_TYPE_RST = 8'h1b;
  localparam logic [7:0] AUDIO_TYPE_RST = 8'h0f;
  localparam logic       REG_VIDEO_TYPE = 1'b0;
  localparam logic       REG_AUDIO_TYPE = 1'b1;

  localparam logic [16:0] COUNT_MAX = 17'h1ffff;

  // result kinds
  localparam logic [1:0] KIND_PAYLOAD  = 2'd0;
  localparam logic [1:0] KIND_COMPLETE = 2'd1;
  localparam logic [1:0] KIND_ERROR    = 2'd2;

  // error codes
  localparam logic [2:0] ERR_NONE       = 3'd0;
  localparam logic [2:0] ERR_ADAPT_ZERO = 3'd1;
  localparam logic [2:0] ERR_PES_PREFIX = 3'd2;
  localparam logic [2:0] ERR_STREAM_TYP = 3'd3;
  localparam logic [2:0] ERR_UNKNOWN_PID = 3'd4;
  localparam logic [2:0] ERR_LENGTH     = 3'd5;
  localparam logic [2:0] ERR_START_CODE = 3'd6;

  typedef enum logic [4:0] {
    PH_HEADER, PH_ADAPT_LEN, PH_ADAPT_SKIP, PH_DROP,
    PH_PTR, PH_PTR_SKIP, PH_TID, PH_SLEN_HI, PH_SLEN_LO,
    PH_PAT_HDR, PH_PAT_ENTRY, PH_PMT_HDR, PH_PMT_PIL_HI, PH_PMT_PIL_LO,
    PH_PMT_INFO, PH_PMT_ES, PH_PMT_ESINFO,
    PH_PES_HDR, PH_PES_PTS, PH_PES_HSKIP, PH_PES_DATA
  } phase_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic        is_video;
    logic [7:0]  payload_byte;
    logic        unit_first;
    logic [16:0] unit_length;
    logic [32:0] unit_pts;
    logic        key_frame;
    logic [2:0]  error_code;
    logic        last;
  } result_t;

endpackage

// ===== hw/rtl/tsd_parser.sv =====
module tsd_parser #(
  parameter int PACKET_BYTES = tsd_pkg::PACKET_BYTES_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic             cfg_addr,
  input  logic [7:0]       cfg_data,
  input  logic             step,
  input  logic [7:0]       byte_in,
  output logic [1:0]       res_n,
  output tsd_pkg::result_t res0,
  output tsd_pkg::result_t res1
);
  import tsd_pkg::*;

  localparam int PW = $clog2(PACKET_BYTES + 1);

  function automatic logic [32:0] decode_pts(input logic [39:0] v);
    decode_pts = {v[35:33], v[31:24], v[23:17], v[15:8], v[7:1]};
  endfunction

  logic [7:0]  video_type, audio_type;
  logic [PW-1:0] pos, pos_next;
  phase_t      ph, ph_next;
  logic [12:0] pid, pid_next;
  logic        usf, usf_next;
  logic [1:0]  fc, fc_next;
  logic [15:0] skip, skip_next;
  logic [11:0] srem, srem_next;
  logic [15:0] fsh, fsh_next;
  logic [7:0]  pst, pst_next;
  logic [12:0] pmt_pid, pmt_pid_next, vpid, vpid_next, apid, apid_next;
  logic [39:0] ptsh, ptsh_next;
  logic [32:0] spts [2];
  logic [32:0] spts_next [2];
  logic [16:0] pcnt [2];
  logic [16:0] pcnt_next [2];
  logic [15:0] elen [2];
  logic [15:0] elen_next [2];
  logic [39:0] vhead, vhead_next;

  // per-byte decode helpers
  logic [PW-1:0] p;
  logic          s;
  logic [16:0]   cnt;
  logic          start_ok, key;
  logic [2:0]    cu_err;
  logic          is_psi, is_str;
  phase_t        ep_ph;
  logic          ep_fail;
  logic          pes_start;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      video_type <= VIDEO_TYPE_RST;
      audio_type <= AUDIO_TYPE_RST;
    end else if (cfg_we) begin
      if (cfg_addr == REG_VIDEO_TYPE) video_type <= cfg_data;
      if (cfg_addr == REG_AUDIO_TYPE) audio_type <= cfg_data;
    end
  end

  // unit completion check for the current stream
  always_comb begin
    s        = (pid == vpid);
    cnt      = pcnt[s];
    start_ok = 1'b1;
    key      = 1'b0;
    if (s) begin
      if (cnt >= 17'd5) begin
        start_ok = (vhead[39:8] == 32'd1);
        key      = start_ok && (vhead[4:0] == 5'd5);
      end else if (cnt == 17'd4) begin
        start_ok = (vhead == 40'd1);
      end else begin
        start_ok = 1'b0;
      end
    end
    if (cnt != {1'b0, elen[s]}) cu_err = ERR_LENGTH;
    else if (!start_ok)         cu_err = ERR_START_CODE;
    else                        cu_err = ERR_NONE;
    is_psi  = (pid == 13'd0) || (pid == pmt_pid);
    is_str  = (pid == vpid) || (pid == apid);
    ep_fail = 1'b0;
    if (is_psi)      ep_ph = usf ? PH_PTR : PH_DROP;
    else if (is_str) ep_ph = usf ? PH_PES_HDR : PH_PES_DATA;
    else begin
      ep_ph   = PH_DROP;
      ep_fail = 1'b1;
    end
  end

  // next state and results
  always_comb begin
    p = (pos >= PW'(PACKET_BYTES)) ? '0 : pos;
    pos_next = (32'(p) + 1 >= PACKET_BYTES) ? '0 : p + PW'(1);
    ph_next = ph; pid_next = pid; usf_next = usf; fc_next = fc;
    skip_next = skip; srem_next = srem; fsh_next = fsh; pst_next = pst;
    pmt_pid_next = pmt_pid; vpid_next = vpid; apid_next = apid;
    ptsh_next = ptsh; vhead_next = vhead;
    spts_next = spts; pcnt_next = pcnt; elen_next = elen;
    pes_start = 1'b0;
    res_n = 2'd0;
    res0 = '0;
    res1 = '0;
    if (p == '0) begin
      ph_next = PH_HEADER;
    end else if (32'(p) < TS_LIMIT) begin
      case (ph)
        PH_HEADER: begin
          if (p == PW'(1)) begin
            usf_next = byte_in[6];
            pid_next = {byte_in[4:0], 8'h00};
          end else if (p == PW'(2)) begin
            pid_next = {pid[12:8], byte_in};
          end else begin
            fc_next = byte_in[5:4];
            if (byte_in[5]) ph_next = PH_ADAPT_LEN;
            else if (byte_in[5:4] == 2'd1) begin
              ph_next = ep_ph;
              if (is_str && !is_psi) skip_next = '0;
              if (ep_fail) begin
                res_n = 2'd1;
                res0.kind = KIND_ERROR;
                res0.error_code = ERR_UNKNOWN_PID;
              end
            end else ph_next = PH_DROP;
          end
        end
        PH_ADAPT_LEN: begin
          if (byte_in == 8'd0) begin
            ph_next = PH_DROP;
            res_n = 2'd1;
            res0.kind = KIND_ERROR;
            res0.error_code = ERR_ADAPT_ZERO;
          end else begin
            skip_next = {8'd0, byte_in};
            ph_next = PH_ADAPT_SKIP;
          end
        end
        PH_ADAPT_SKIP: begin
          skip_next = skip - 16'd1;
          if (skip == 16'd1) begin
            if (fc == 2'd3) begin
              ph_next = ep_ph;
              if (is_str && !is_psi) skip_next = '0;
              if (ep_fail) begin
                res_n = 2'd1;
                res0.kind = KIND_ERROR;
                res0.error_code = ERR_UNKNOWN_PID;
              end
            end else ph_next = PH_DROP;
          end
        end
        PH_DROP: ;
        PH_PTR: begin
          skip_next = {8'd0, byte_in};
          ph_next = (byte_in != 8'd0) ? PH_PTR_SKIP : PH_TID;
        end
        PH_PTR_SKIP: begin
          skip_next = skip - 16'd1;
          if (skip == 16'd1) ph_next = PH_TID;
        end
        PH_TID: ph_next = PH_SLEN_HI;
        PH_SLEN_HI: begin
          fsh_next = {12'd0, byte_in[3:0]};
          ph_next = PH_SLEN_LO;
        end
        PH_SLEN_LO: begin
          srem_next = {fsh[3:0], byte_in};
          skip_next = (pid == 13'd0) ? 16'd5 : 16'd7;
          ph_next = (pid == 13'd0) ? PH_PAT_HDR : PH_PMT_HDR;
        end
        PH_PAT_HDR, PH_PAT_ENTRY, PH_PMT_HDR, PH_PMT_PIL_HI,
        PH_PMT_PIL_LO, PH_PMT_INFO, PH_PMT_ES, PH_PMT_ESINFO: begin
          if (srem == 12'd0) ph_next = PH_DROP;
          else begin
            srem_next = srem - 12'd1;
            case (ph)
              PH_PAT_HDR, PH_PMT_HDR: begin
                skip_next = skip - 16'd1;
                if (skip == 16'd1)
                  ph_next = (ph == PH_PAT_HDR) ? PH_PAT_ENTRY : PH_PMT_PIL_HI;
              end
              PH_PAT_ENTRY: begin
                skip_next = {14'd0, skip[1:0] + 2'd1};
                if (skip == 16'd0) begin
                  if (srem < 12'd8) ph_next = PH_DROP;
                  else fsh_next = {8'd0, byte_in};
                end else if (skip == 16'd1) begin
                  fsh_next = ({fsh[7:0], byte_in} != 16'd0) ? 16'd1 : 16'd0;
                end else if (skip == 16'd2) begin
                  fsh_next = {fsh[0], 2'b00, byte_in[4:0], 8'h00};
                end else if (fsh[15]) begin
                  pmt_pid_next = {fsh[12:8], byte_in};
                end
              end
              PH_PMT_PIL_HI: begin
                fsh_next = {12'd0, byte_in[3:0]};
                ph_next = PH_PMT_PIL_LO;
              end
              PH_PMT_PIL_LO: begin
                skip_next = {4'd0, fsh[3:0], byte_in};
                ph_next = ({fsh[3:0], byte_in} != 12'd0) ? PH_PMT_INFO : PH_PMT_ES;
              end
              PH_PMT_INFO, PH_PMT_ESINFO: begin
                skip_next = skip - 16'd1;
                if (skip == 16'd1) ph_next = PH_PMT_ES;
              end
              default: begin
                // elementary stream loop entry
                if (skip == 16'd0) begin
                  if (srem <= 12'd4) ph_next = PH_DROP;
                  else begin
                    pst_next = byte_in;
                    skip_next = 16'd1;
                  end
                end else if (skip == 16'd1) begin
                  fsh_next = {11'd0, byte_in[4:0]};
                  skip_next = 16'd2;
                end else if (skip == 16'd2) begin
                  if (pst == video_type) begin
                    vpid_next = {fsh[4:0], byte_in};
                    skip_next = 16'd3;
                  end else if (pst == audio_type) begin
                    apid_next = {fsh[4:0], byte_in};
                    skip_next = 16'd3;
                  end else begin
                    ph_next = PH_DROP;
                    res_n = 2'd1;
                    res0.kind = KIND_ERROR;
                    res0.error_code = ERR_STREAM_TYP;
                  end
                end else if (skip == 16'd3) begin
                  fsh_next = {12'd0, byte_in[3:0]};
                  skip_next = 16'd4;
                end else begin
                  skip_next = {4'd0, fsh[3:0], byte_in};
                  ph_next = ({fsh[3:0], byte_in} != 12'd0) ? PH_PMT_ESINFO : PH_PMT_ES;
                end
              end
            endcase
          end
        end
        PH_PES_HDR: begin
          skip_next = skip + 16'd1;
          if ((skip <= 16'd1 && byte_in != 8'd0) ||
              (skip == 16'd2 && byte_in != 8'd1)) begin
            skip_next = skip;
            ph_next = PH_DROP;
            res_n = 2'd1;
            res0.kind = KIND_ERROR;
            res0.is_video = s;
            res0.error_code = ERR_PES_PREFIX;
          end else if (skip == 16'd2) begin
            pes_start = 1'b1;
          end else if (skip == 16'd4) begin
            fsh_next = {8'd0, byte_in};
          end else if (skip == 16'd5) begin
            fsh_next = {fsh[7:0], byte_in};
          end else if (skip == 16'd7) begin
            ptsh_next = {39'd0, byte_in[7]};
          end else if (skip >= 16'd8) begin
            elen_next[s] = fsh - 16'd3 - {8'd0, byte_in};
            spts_next[s] = '0;
            ptsh_next = '0;
            fsh_next = '0;
            skip_next = {8'd0, byte_in};
            if (byte_in == 8'd0) ph_next = PH_PES_DATA;
            else ph_next = ptsh[0] ? PH_PES_PTS : PH_PES_HSKIP;
          end
        end
        PH_PES_PTS: begin
          ptsh_next = {ptsh[31:0], byte_in};
          fsh_next = fsh + 16'd1;
          skip_next = skip - 16'd1;
          if (fsh == 16'd4) begin
            spts_next[s] = decode_pts({ptsh[31:0], byte_in});
            ph_next = (skip != 16'd1) ? PH_PES_HSKIP : PH_PES_DATA;
          end else if (skip == 16'd1) begin
            ph_next = PH_PES_DATA;
          end
        end
        PH_PES_HSKIP: begin
          skip_next = skip - 16'd1;
          if (skip == 16'd1) ph_next = PH_PES_DATA;
        end
        PH_PES_DATA: begin
          res_n = 2'd1;
          res0.kind = KIND_PAYLOAD;
          res0.is_video = s;
          res0.payload_byte = byte_in;
          res0.unit_first = (cnt == 17'd0);
          if (s && cnt < 17'd5) vhead_next = {vhead[31:0], byte_in};
          if (cnt < COUNT_MAX) pcnt_next[s] = cnt + 17'd1;
        end
        default: ph_next = PH_DROP;
      endcase
    end
    // report the previous unit of this stream
    if (pes_start && cnt != 17'd0) begin
      res0.kind = KIND_COMPLETE;
      res0.is_video = s;
      res0.unit_length = cnt;
      res0.unit_pts = spts[s];
      res0.key_frame = key;
      res1.kind = KIND_ERROR;
      res1.is_video = s;
      res1.error_code = cu_err;
      res_n = (cu_err != ERR_NONE) ? 2'd2 : 2'd1;
      pcnt_next[s] = '0;
      if (s) vhead_next = '0;
    end
    res0.last = (res_n == 2'd1);
    res1.last = 1'b1;
  end

  // parser state
  always_ff @(posedge clk) begin
    if (rst) begin
      pos <= '0; ph <= PH_HEADER; pid <= '0; usf <= 1'b0; fc <= '0;
      skip <= '0; srem <= '0; fsh <= '0; pst <= '0;
      pmt_pid <= '0; vpid <= '0; apid <= '0; ptsh <= '0; vhead <= '0;
      spts[0] <= '0; spts[1] <= '0; pcnt[0] <= '0; pcnt[1] <= '0;
      elen[0] <= '0; elen[1] <= '0;
    end else if (step) begin
      pos <= pos_next; ph <= ph_next; pid <= pid_next; usf <= usf_next;
      fc <= fc_next; skip <= skip_next; srem <= srem_next; fsh <= fsh_next;
      pst <= pst_next; pmt_pid <= pmt_pid_next; vpid <= vpid_next;
      apid <= apid_next; ptsh <= ptsh_next; vhead <= vhead_next;
      spts <= spts_next; pcnt <= pcnt_next; elen <= elen_next;
    end
  end

endmodule

// ===== hw/rtl/tsd_result_fifo.sv =====
module tsd_result_fifo (
  input  logic             clk,
  input  logic             rst,
  input  logic [1:0]       push_n,
  input  tsd_pkg::result_t push0,
  input  tsd_pkg::result_t push1,
  input  logic             pop,
  output logic             room2,
  output logic             valid,
  output tsd_pkg::result_t head
);
  import tsd_pkg::*;

  result_t    mem [4];
  logic [1:0] wr, rd;
  logic [2:0] count;
  logic       do_pop;

  assign do_pop = pop && valid;
  assign valid  = (count != 3'd0);
  assign room2  = (count <= 3'd2);
  assign head   = mem[rd];

  // storage writes
  always_ff @(posedge clk) begin
    if (push_n != 2'd0) mem[wr] <= push0;
    if (push_n == 2'd2) mem[wr + 2'd1] <= push1;
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr <= '0;
      rd <= '0;
      count <= '0;
    end else begin
      wr <= wr + push_n;
      rd <= rd + {1'b0, do_pop};
      count <= count + {1'b0, push_n} - {2'b00, do_pop};
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    (count + {1'b0, push_n}) <= 3'd4)
    else $error("result queue overflow");
  a_level_bound: assert property (@(posedge clk) disable iff (rst)
    count <= 3'd4)
    else $error("result queue level out of range");
  a_reset_empty: assert property (@(posedge clk) rst |=> count == 3'd0)
    else $error("result queue not empty after reset");

endmodule

// ===== hw/rtl/transport_stream_demux_core.sv =====
// transport stream demultiplexer
// s_axis carries the packet-aligned transport stream, one byte per beat
// (tdata[7:0] = stream_byte). m_axis carries results: tuser gives the kind
// and stream, tdata the payload byte or unit report, tlast marks the last
// result caused by one input byte (one byte gives zero, one or two results).
// cfg_we/cfg_addr/cfg_data write the video (0) and audio (1) stream types.
// A byte taken into the input register is parsed there once the result queue has
// room for two results, and its results are then offered from the queue.
// One byte per cycle is accepted while the four-entry result queue has room
// for two results; the queue drains one result per cycle while m_axis_tready
// is high, so the rate is one byte per cycle unless a byte yields two results.
// Reset clears all parse state, the learned PIDs and the queue, and loads
// the stream type registers with 0x1b (video) and 0x0f (audio).
// When the receiver stalls the queue fills and s_axis_tready drops; no
// result is lost.
module transport_stream_demux_core #(
  parameter int PACKET_BYTES = tsd_pkg::PACKET_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,  // [7:0] stream_byte
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [7:0] payload_byte, [8] unit_first, [25:9] unit_length,
  // [58:26] unit_pts, [59] key_frame, [62:60] error_code, [63] zero
  output logic [63:0] m_axis_tdata,
  output logic [2:0]  m_axis_tuser,  // [1:0] result_kind, [2] is_video
  output logic        m_axis_tlast,
  input  logic        cfg_we,
  input  logic        cfg_addr,
  input  logic [7:0]  cfg_data
);
  import tsd_pkg::*;

  logic       in_valid;
  logic [7:0] in_byte;
  logic       step, room2, q_valid;
  logic [1:0] res_n;
  result_t    res0, res1, head;

  assign step = in_valid && room2;
  assign s_axis_tready = !in_valid || step;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tready && s_axis_tvalid) in_byte <= s_axis_tdata;
  end

  tsd_parser #(.PACKET_BYTES(PACKET_BYTES)) u_parser (
    .clk, .rst, .cfg_we, .cfg_addr, .cfg_data,
    .step, .byte_in(in_byte),
    .res_n, .res0, .res1
  );

  tsd_result_fifo u_queue (
    .clk, .rst,
    .push_n(step ? res_n : 2'd0),
    .push0(res0), .push1(res1),
    .pop(m_axis_tready),
    .room2, .valid(q_valid), .head
  );

  // result packing
  assign m_axis_tvalid = q_valid;
  assign m_axis_tdata  = {1'b0, head.error_code, head.key_frame, head.unit_pts,
                          head.unit_length, head.unit_first, head.payload_byte};
  assign m_axis_tuser  = {head.is_video, head.kind};
  assign m_axis_tlast  = head.last;

endmodule

// ===== bench/testbench.sv =====
module testbench;
  import tsd_pkg::*;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = 8'h00;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [63:0] m_axis_tdata;
  logic [2:0]  m_axis_tuser;
  logic        m_axis_tlast;
  logic        cfg_we = 1'b0;
  logic        cfg_addr = 1'b0;
  logic [7:0]  cfg_data = 8'h00;

  transport_stream_demux_core uut (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
    .m_axis_tlast(m_axis_tlast),
    .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_data(cfg_data)
  );

  // clock, period 20
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  bit      calm = 1'b0;
  int      fails = 0;
  result_t pending_results[$];
  result_t step_out[$];
  logic [7:0] pkt [0:187];

  // demux state mirror
  logic [7:0]  vid_type, aud_type;
  int          pkt_pos;
  phase_t      phase;
  logic [12:0] cur_pid, pmt_pid, vid_pid, aud_pid;
  logic        pusi;
  logic [1:0]  afc;
  logic [15:0] skip;
  logic [11:0] sect_left;
  logic [15:0] fshift;
  logic [7:0]  pend_type;
  logic [39:0] pts_acc;
  logic [32:0] unit_pts [0:1];
  logic [16:0] unit_cnt [0:1];
  logic [15:0] unit_exp [0:1];
  logic [39:0] vhead;

  function automatic void demux_reset();
    vid_type = VIDEO_TYPE_RST; aud_type = AUDIO_TYPE_RST;
    pkt_pos = 0; phase = PH_HEADER; cur_pid = '0; pusi = 1'b0; afc = '0;
    skip = '0; sect_left = '0; fshift = '0; pend_type = '0;
    pmt_pid = '0; vid_pid = '0; aud_pid = '0; pts_acc = '0; vhead = '0;
    for (int i = 0; i < 2; i++) begin
      unit_pts[i] = '0; unit_cnt[i] = '0; unit_exp[i] = '0;
    end
  endfunction

  function automatic void put_result(logic [1:0] kind, logic isv, logic [7:0] pb,
                                     logic first, logic [16:0] len, logic [32:0] pts,
                                     logic key, logic [2:0] err);
    result_t r;
    if (step_out.size() >= 2) return;
    r.kind = kind; r.is_video = isv; r.payload_byte = pb; r.unit_first = first;
    r.unit_length = len; r.unit_pts = pts; r.key_frame = key; r.error_code = err;
    r.last = 1'b0;
    step_out.push_back(r);
  endfunction

  function automatic void raise_error(logic [2:0] code, logic isv);
    put_result(KIND_ERROR, isv, 8'h00, 1'b0, '0, '0, 1'b0, code);
    phase = PH_DROP;
  endfunction

  function automatic void open_payload();
    if (cur_pid == 13'd0 || cur_pid == pmt_pid) begin
      phase = pusi ? PH_PTR : PH_DROP;
    end else if (cur_pid == vid_pid || cur_pid == aud_pid) begin
      skip = '0;
      phase = pusi ? PH_PES_HDR : PH_PES_DATA;
    end else begin
      raise_error(ERR_UNKNOWN_PID, 1'b0);
    end
  endfunction

  // report the unit collected so far on one stream
  function automatic void close_unit(int s);
    logic [16:0] cnt;
    logic        key, start;
    logic [2:0]  err;
    cnt = unit_cnt[s]; key = 1'b0; start = 1'b1; err = ERR_NONE;
    if (cnt == 0) return;
    if (s == 1) begin
      if (cnt >= 5) begin
        start = (vhead[39:8] == 32'd1);
        key = start && (vhead[4:0] == 5'd5);
      end else if (cnt == 4) begin
        start = (vhead == 40'd1);
      end else begin
        start = 1'b0;
      end
    end
    if (cnt != {1'b0, unit_exp[s]}) err = ERR_LENGTH;
    else if (!start) err = ERR_START_CODE;
    put_result(KIND_COMPLETE, s[0], 8'h00, 1'b0, cnt, unit_pts[s], key, ERR_NONE);
    if (err != ERR_NONE) put_result(KIND_ERROR, s[0], 8'h00, 1'b0, '0, '0, 1'b0, err);
    unit_cnt[s] = '0;
    if (s == 1) vhead = '0;
  endfunction

  function automatic void section_step(logic [7:0] b);
    logic [11:0] rem;
    logic [12:0] p;
    rem = sect_left;
    if (rem == 0) begin
      phase = PH_DROP;
      return;
    end
    sect_left = rem - 12'd1;
    case (phase)
      PH_PAT_HDR: begin
        skip = skip - 16'd1;
        if (skip == 0) phase = PH_PAT_ENTRY;
      end
      PH_PAT_ENTRY: begin
        if (skip == 0) begin
          if (rem < 8) begin
            phase = PH_DROP;
            return;
          end
          fshift = {8'h00, b};
        end else if (skip == 1) begin
          fshift = ({fshift[7:0], b} != 16'd0) ? 16'd1 : 16'd0;
        end else if (skip == 2) begin
          fshift = {fshift[0], 2'b00, b[4:0], 8'h00};
        end else begin
          p = {fshift[12:8], b};
          if (fshift[15]) pmt_pid = p;
        end
        skip = (skip + 16'd1) & 16'd3;
      end
      PH_PMT_HDR: begin
        skip = skip - 16'd1;
        if (skip == 0) phase = PH_PMT_PIL_HI;
      end
      PH_PMT_PIL_HI: begin
        fshift = {12'h000, b[3:0]};
        phase = PH_PMT_PIL_LO;
      end
      PH_PMT_PIL_LO: begin
        skip = {4'h0, fshift[3:0], b};
        phase = (skip != 0) ? PH_PMT_INFO : PH_PMT_ES;
      end
      PH_PMT_INFO, PH_PMT_ESINFO: begin
        skip = skip - 16'd1;
        if (skip == 0) phase = PH_PMT_ES;
      end
      default: begin
        // elementary stream loop entry
        if (skip == 0) begin
          if (rem <= 4) begin
            phase = PH_DROP;
            return;
          end
          pend_type = b;
          skip = 16'd1;
        end else if (skip == 1) begin
          fshift = {11'h000, b[4:0]};
          skip = 16'd2;
        end else if (skip == 2) begin
          p = {fshift[4:0], b};
          if (pend_type == vid_type) vid_pid = p;
          else if (pend_type == aud_type) aud_pid = p;
          else begin
            raise_error(ERR_STREAM_TYP, 1'b0);
            return;
          end
          skip = 16'd3;
        end else if (skip == 3) begin
          fshift = {12'h000, b[3:0]};
          skip = 16'd4;
        end else begin
          skip = {4'h0, fshift[3:0], b};
          phase = (skip != 0) ? PH_PMT_ESINFO : PH_PMT_ES;
        end
      end
    endcase
  endfunction

  function automatic void pes_step(logic [7:0] b);
    int   s;
    logic has_pts;
    s = (cur_pid == vid_pid) ? 1 : 0;
    case (phase)
      PH_PES_HDR: begin
        if (skip <= 1 && b != 8'h00) begin
          raise_error(ERR_PES_PREFIX, s[0]);
          return;
        end
        if (skip == 2) begin
          if (b != 8'h01) begin
            raise_error(ERR_PES_PREFIX, s[0]);
            return;
          end
          close_unit(s);
        end else if (skip == 4) begin
          fshift = {8'h00, b};
        end else if (skip == 5) begin
          fshift = {fshift[7:0], b};
        end else if (skip == 7) begin
          pts_acc = {39'd0, b[7]};
        end else if (skip >= 8) begin
          has_pts = pts_acc[0];
          unit_exp[s] = fshift - 16'd3 - {8'h00, b};
          unit_pts[s] = '0;
          pts_acc = '0;
          fshift = '0;
          skip = {8'h00, b};
          phase = (b == 0) ? PH_PES_DATA : (has_pts ? PH_PES_PTS : PH_PES_HSKIP);
          return;
        end
        skip = skip + 16'd1;
      end
      PH_PES_PTS: begin
        pts_acc = {pts_acc[31:0], b};
        fshift = fshift + 16'd1;
        skip = skip - 16'd1;
        if (fshift == 5) begin
          unit_pts[s] = {pts_acc[35:33], pts_acc[31:24], pts_acc[23:17],
                         pts_acc[15:8], pts_acc[7:1]};
          phase = (skip != 0) ? PH_PES_HSKIP : PH_PES_DATA;
        end else if (skip == 0) begin
          phase = PH_PES_DATA;
        end
      end
      PH_PES_HSKIP: begin
        skip = skip - 16'd1;
        if (skip == 0) phase = PH_PES_DATA;
      end
      default: begin
        put_result(KIND_PAYLOAD, s[0], b, unit_cnt[s] == 0, '0, '0, 1'b0, ERR_NONE);
        if (s == 1 && unit_cnt[s] < 5) vhead = {vhead[31:0], b};
        if (unit_cnt[s] < COUNT_MAX) unit_cnt[s] = unit_cnt[s] + 17'd1;
      end
    endcase
  endfunction

  // one accepted stream byte: update the mirror, queue what it yields
  function automatic void demux_step(logic [7:0] b);
    int pos;
    pos = pkt_pos;
    step_out.delete();
    if (pos == 0) begin
      phase = PH_HEADER;
    end else begin
      case (phase)
        PH_HEADER: begin
          if (pos == 1) begin
            pusi = b[6];
            cur_pid = {b[4:0], 8'h00};
          end else if (pos == 2) begin
            cur_pid[7:0] = b;
          end else begin
            afc = b[5:4];
            if (afc[1]) phase = PH_ADAPT_LEN;
            else if (afc == 2'd1) open_payload();
            else phase = PH_DROP;
          end
        end
        PH_ADAPT_LEN: begin
          if (b == 0) raise_error(ERR_ADAPT_ZERO, 1'b0);
          else begin
            skip = {8'h00, b};
            phase = PH_ADAPT_SKIP;
          end
        end
        PH_ADAPT_SKIP: begin
          skip = skip - 16'd1;
          if (skip == 0) begin
            if (afc == 2'd3) open_payload();
            else phase = PH_DROP;
          end
        end
        PH_DROP: ;
        PH_PTR: begin
          skip = {8'h00, b};
          phase = (b != 0) ? PH_PTR_SKIP : PH_TID;
        end
        PH_PTR_SKIP: begin
          skip = skip - 16'd1;
          if (skip == 0) phase = PH_TID;
        end
        PH_TID: phase = PH_SLEN_HI;
        PH_SLEN_HI: begin
          fshift = {12'h000, b[3:0]};
          phase = PH_SLEN_LO;
        end
        PH_SLEN_LO: begin
          sect_left = {fshift[3:0], b};
          skip = (cur_pid == 0) ? 16'd5 : 16'd7;
          phase = (cur_pid == 0) ? PH_PAT_HDR : PH_PMT_HDR;
        end
        PH_PAT_HDR, PH_PAT_ENTRY, PH_PMT_HDR, PH_PMT_PIL_HI, PH_PMT_PIL_LO,
        PH_PMT_INFO, PH_PMT_ES, PH_PMT_ESINFO: section_step(b);
        PH_PES_HDR, PH_PES_PTS, PH_PES_HSKIP, PH_PES_DATA: pes_step(b);
        default: phase = PH_DROP;
      endcase
    end
    pkt_pos = (pos + 1 >= 188) ? 0 : pos + 1;
    if (step_out.size() > 0) step_out[step_out.size() - 1].last = 1'b1;
    foreach (step_out[i]) pending_results.push_back(step_out[i]);
  endfunction

  // result checker
  always @(posedge clk) begin
    result_t e;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (pending_results.size() == 0) begin
        $error("result beat with nothing expected");
        fails++;
      end else begin
        e = pending_results.pop_front();
        if (m_axis_tuser[1:0] !== e.kind) begin
          $error("result_kind exp %0d got %0d", e.kind, m_axis_tuser[1:0]); fails++;
        end
        if (m_axis_tuser[2] !== e.is_video) begin
          $error("is_video exp %0d got %0d", e.is_video, m_axis_tuser[2]); fails++;
        end
        if (m_axis_tdata[7:0] !== e.payload_byte) begin
          $error("payload_byte exp %h got %h", e.payload_byte, m_axis_tdata[7:0]); fails++;
        end
        if (m_axis_tdata[8] !== e.unit_first) begin
          $error("unit_first exp %0d got %0d", e.unit_first, m_axis_tdata[8]); fails++;
        end
        if (m_axis_tdata[25:9] !== e.unit_length) begin
          $error("unit_length exp %0d got %0d", e.unit_length, m_axis_tdata[25:9]); fails++;
        end
        if (m_axis_tdata[58:26] !== e.unit_pts) begin
          $error("unit_pts exp %h got %h", e.unit_pts, m_axis_tdata[58:26]); fails++;
        end
        if (m_axis_tdata[59] !== e.key_frame) begin
          $error("key_frame exp %0d got %0d", e.key_frame, m_axis_tdata[59]); fails++;
        end
        if (m_axis_tdata[62:60] !== e.error_code) begin
          $error("error_code exp %0d got %0d", e.error_code, m_axis_tdata[62:60]); fails++;
        end
        if (m_axis_tlast !== e.last) begin
          $error("last exp %0d got %0d", e.last, m_axis_tlast); fails++;
        end
      end
    end
  end

  // receiver stalls
  always @(negedge clk) begin
    m_axis_tready <= calm || ($urandom_range(0, 99) >= 34);
  end

  // stream byte sender, leaves tvalid high for a following beat
  task automatic send_byte(input logic [7:0] b);
    if (!calm) begin
      while ($urandom_range(0, 99) < 34) begin
        s_axis_tvalid = 1'b0;
        @(negedge clk);
      end
    end
    s_axis_tvalid = 1'b1;
    s_axis_tdata = b;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    demux_step(b);
    @(negedge clk);
  endtask

  task automatic send_packet();
    for (int i = 0; i < 188; i++) send_byte(pkt[i]);
  endtask

  // hold the sender until every expected result has arrived
  task automatic drain();
    s_axis_tvalid = 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (10) @(negedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [7:0] val);
    drain();
    cfg_we = 1'b1; cfg_addr = idx; cfg_data = val;
    @(negedge clk);
    cfg_we = 1'b0;
    if (idx == REG_VIDEO_TYPE) vid_type = val;
    else aud_type = val;
  endtask

  // header, optional adaptation field; returns the first payload index
  function automatic int packet_head(logic [12:0] pid, logic start, logic [1:0] ctl,
                                     int alen);
    for (int i = 0; i < 188; i++) pkt[i] = 8'($urandom_range(0, 255));
    pkt[0] = 8'h47;
    pkt[1] = {1'b0, start, 1'b0, pid[12:8]};
    pkt[2] = pid[7:0];
    pkt[3] = {2'b00, ctl, 4'h0};
    if (ctl[1]) begin
      pkt[4] = alen[7:0];
      return 5 + alen;
    end
    return 4;
  endfunction

  task automatic send_pat(input logic [12:0] map_pid, input int ptr, input bit net);
    int k, n, slen;
    k = packet_head(13'd0, 1'b1, 2'd1, 0);
    n = net ? 2 : 1;
    slen = 5 + 4 * n + 4;
    pkt[k] = ptr[7:0];
    k = k + 1 + ptr;
    pkt[k] = 8'h00;
    pkt[k + 1] = {4'hB, slen[11:8]};
    pkt[k + 2] = slen[7:0];
    k = k + 8;
    if (net) begin
      pkt[k] = 8'h00; pkt[k + 1] = 8'h00; pkt[k + 2] = 8'hE0; pkt[k + 3] = 8'h10;
      k = k + 4;
    end
    pkt[k] = 8'h00; pkt[k + 1] = 8'h01;
    pkt[k + 2] = {3'b111, map_pid[12:8]}; pkt[k + 3] = map_pid[7:0];
    send_packet();
  endtask

  task automatic send_pmt(input logic [12:0] pid, input logic [7:0] t1,
                          input logic [12:0] p1, input logic [7:0] t2,
                          input logic [12:0] p2, input int pil, input int esl);
    int k, slen;
    k = packet_head(pid, 1'b1, 2'd1, 0);
    slen = 9 + pil + 2 * (5 + esl) + 4;
    pkt[k] = 8'h00;
    pkt[k + 1] = 8'h02;
    pkt[k + 2] = {4'hB, slen[11:8]};
    pkt[k + 3] = slen[7:0];
    k = k + 11;
    pkt[k] = {4'hF, pil[11:8]}; pkt[k + 1] = pil[7:0];
    k = k + 2 + pil;
    pkt[k] = t1; pkt[k + 1] = {3'b111, p1[12:8]}; pkt[k + 2] = p1[7:0];
    pkt[k + 3] = {4'hF, esl[11:8]}; pkt[k + 4] = esl[7:0];
    k = k + 5 + esl;
    pkt[k] = t2; pkt[k + 1] = {3'b111, p2[12:8]}; pkt[k + 2] = p2[7:0];
    pkt[k + 3] = {4'hF, esl[11:8]}; pkt[k + 4] = esl[7:0];
    send_packet();
  endtask

  // one PES unit: a start packet and some continuation packets
  task automatic send_unit(input logic [12:0] pid, input bit video, input bit scode,
                           input bit key, input bit has_pts, input int hdl,
                           input int conts, input bit good_len, input int alen,
                           input bit bad_prefix);
    int k, n0, total;
    logic [15:0] plen;
    logic [32:0] pts;
    k = packet_head(pid, 1'b1, (alen > 0) ? 2'd3 : 2'd1, alen);
    n0 = 188 - k - 9 - hdl;
    total = n0 + conts * 184;
    plen = good_len ? 16'(3 + hdl + total) : 16'($urandom_range(0, 65535));
    pts = {1'($urandom_range(0, 1)), $urandom()};
    pkt[k] = bad_prefix ? 8'h01 : 8'h00;
    pkt[k + 1] = 8'h00; pkt[k + 2] = 8'h01;
    pkt[k + 3] = video ? 8'hE0 : 8'hC0;
    pkt[k + 4] = plen[15:8]; pkt[k + 5] = plen[7:0];
    pkt[k + 6] = 8'h80; pkt[k + 7] = has_pts ? 8'h80 : 8'h00;
    pkt[k + 8] = hdl[7:0];
    k = k + 9;
    if (has_pts && hdl >= 5) begin
      pkt[k] = {4'b0010, pts[32:30], 1'b1}; pkt[k + 1] = pts[29:22];
      pkt[k + 2] = {pts[21:15], 1'b1}; pkt[k + 3] = pts[14:7];
      pkt[k + 4] = {pts[6:0], 1'b1};
    end
    k = k + hdl;
    if (video && scode && n0 >= 5) begin
      pkt[k] = 8'h00; pkt[k + 1] = 8'h00; pkt[k + 2] = 8'h00; pkt[k + 3] = 8'h01;
      pkt[k + 4] = key ? 8'h65 : 8'h41;
    end
    send_packet();
    for (int c = 0; c < conts; c++) begin
      void'(packet_head(pid, 1'b0, 2'd1, 0));
      send_packet();
    end
  endtask

  task automatic send_plain(input logic [12:0] pid, input logic start,
                            input logic [1:0] ctl, input int alen);
    void'(packet_head(pid, start, ctl, alen));
    send_packet();
  endtask

  // PSI learning with reset stream types, then a unit on each stream
  task automatic test_learning();
    send_pat(13'h100, 2, 1'b1);
    send_pmt(13'h100, VIDEO_TYPE_RST, 13'h101, AUDIO_TYPE_RST, 13'h102, 2, 1);
    send_unit(13'h101, 1, 1, 1, 1, 5, 0, 1, 0, 0);
    send_unit(13'h102, 0, 0, 0, 1, 5, 0, 0, 0, 0);  // length mismatch
  endtask

  task automatic test_special_cases();
    send_plain(13'h101, 1'b0, 2'd3, 0);              // zero adaptation length
    calm = 1'b1;
    send_unit(13'h101, 1, 0, 0, 0, 2, 0, 1, 20, 0);  // no start code
    calm = 1'b0;
    send_unit(13'h102, 0, 0, 0, 0, 0, 0, 1, 0, 0);
  endtask

  // same code on both registers: video takes it, unknown code flags
  task automatic test_stream_types();
    write_reg(REG_VIDEO_TYPE, 8'h80);
    write_reg(REG_AUDIO_TYPE, 8'h80);
    send_pmt(13'h100, 8'h80, 13'h0201, 8'h33, 13'h0202, 0, 2);
    send_unit(13'h0201, 1, 1, 1, 1, 5, 0, 1, 0, 0);
  endtask

  initial begin
    demux_reset();
    repeat (5) @(negedge clk);
    rst = 1'b0;
    test_learning();
    test_special_cases();
    test_stream_types();
    drain();
    if (fails == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end

  // run limit
  initial begin
    #100000000;
    $display("Verification failed");
    $finish;
  end

endmodule
